/* sv/hsv_hsl_to_rgb_converter_macros.svh */
// Assertion macros shared by the checker.
`ifndef HSV_HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_HSL_TO_RGB_CONVERTER_MACROS_SVH

// Overlapping implication, quiet during reset.
`define HHR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define HHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked through reset.
`define HHR_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hhr_pkg.sv */
package hhr_pkg;

  localparam int FRAC_BITS            = 12;
  localparam int HUE_STEPS_PER_DEGREE = 64;

  localparam int HUE_W  = 15;
  localparam int Q_W    = 13;
  localparam int F_W    = 12;
  localparam int M2_W   = 14;
  localparam int PROD_W = 24;
  localparam int BYTE_W = 8;

  localparam int ONE_Q    = 1 << FRAC_BITS;
  localparam int SECTOR_W = 60 * HUE_STEPS_PER_DEGREE;
  localparam int TURN_W   = 360 * HUE_STEPS_PER_DEGREE;

  // SECTOR_W = 256 * 15: shift by 8, then divide by 15 through a reciprocal
  localparam int DIV_SHIFT   = 8;
  localparam int DIV_ODD     = 15;
  localparam int QUO_W       = PROD_W - DIV_SHIFT;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = ((1 << RECIP_SHIFT) - 1) / DIV_ODD;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [Q_W-1:0]   saturation;
    logic [Q_W-1:0]   level;
  } pixel_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } pixel_out_t;

  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_C,
    SLOT_X
  } slot_t;

  typedef struct packed {
    slot_t r;
    slot_t g;
    slot_t b;
  } slot_map_t;

  typedef enum logic {
    MODEL_HSV,
    MODEL_HSL
  } model_t;

  typedef struct packed {
    logic [2:0]     sector;
    logic [F_W-1:0] f;
    logic [Q_W-1:0] mul_a;
    logic [Q_W-1:0] sat;
    logic [Q_W-1:0] lev;
    model_t         model;
  } s1_t;

  typedef struct packed {
    logic [2:0]     sector;
    logic [F_W-1:0] f;
    logic [Q_W-1:0] c;
    logic [Q_W-1:0] lev;
    model_t         model;
  } s2_t;

  typedef struct packed {
    logic [2:0]        sector;
    logic [Q_W-1:0]    c;
    logic [M2_W-1:0]   m2;
    logic [PROD_W-1:0] prod;
  } s3_t;

  typedef struct packed {
    logic [2:0]       sector;
    logic [Q_W-1:0]   c;
    logic [M2_W-1:0]  m2;
    logic [QUO_W-1:0] q;
    logic [Q_W-1:0]   est;
  } s4_t;

  typedef struct packed {
    logic [M2_W-1:0] r2;
    logic [M2_W-1:0] g2;
    logic [M2_W-1:0] b2;
  } s5_t;

  function automatic slot_map_t sector_slots(input logic [2:0] sector);
    slot_map_t m;
    unique case (sector)
      3'd0:    m = '{r: SLOT_C,    g: SLOT_X,    b: SLOT_ZERO};
      3'd1:    m = '{r: SLOT_X,    g: SLOT_C,    b: SLOT_ZERO};
      3'd2:    m = '{r: SLOT_ZERO, g: SLOT_C,    b: SLOT_X};
      3'd3:    m = '{r: SLOT_ZERO, g: SLOT_X,    b: SLOT_C};
      3'd4:    m = '{r: SLOT_X,    g: SLOT_ZERO, b: SLOT_C};
      default: m = '{r: SLOT_C,    g: SLOT_ZERO, b: SLOT_X};
    endcase
    return m;
  endfunction

endpackage

/* sv/hhr_prep.sv */
module hhr_prep (
  input  logic               clk,
  input  logic               en,
  input  hhr_pkg::pixel_in_t pix,
  input  hhr_pkg::model_t    model,
  output hhr_pkg::s1_t       s1_r
);

  logic [hhr_pkg::HUE_W-1:0] hue_red;
  logic [hhr_pkg::HUE_W-1:0] base;
  logic [2:0]                sector;
  logic [hhr_pkg::F_W-1:0]   rem;
  logic [hhr_pkg::Q_W-1:0]   sat_c;
  logic [hhr_pkg::Q_W-1:0]   lev_c;
  logic [hhr_pkg::M2_W-1:0]  lev2;
  logic [hhr_pkg::M2_W-1:0]  lev_dev;
  hhr_pkg::s1_t              s1_nxt;

  always_comb begin
    // 15-bit hue stays below two turns, one subtract reduces it
    if (pix.hue >= hhr_pkg::HUE_W'(hhr_pkg::TURN_W)) begin
      hue_red = pix.hue - hhr_pkg::HUE_W'(hhr_pkg::TURN_W);
    end else begin
      hue_red = pix.hue;
    end

    sector = '0;
    base   = '0;
    for (int k = 1; k < 6; k++) begin
      if (hue_red >= hhr_pkg::HUE_W'(k * hhr_pkg::SECTOR_W)) begin
        sector = 3'(k);
        base   = hhr_pkg::HUE_W'(k * hhr_pkg::SECTOR_W);
      end
    end
    rem = hhr_pkg::F_W'(hue_red - base);

    sat_c = (pix.saturation > hhr_pkg::Q_W'(hhr_pkg::ONE_Q)) ?
            hhr_pkg::Q_W'(hhr_pkg::ONE_Q) : pix.saturation;
    lev_c = (pix.level > hhr_pkg::Q_W'(hhr_pkg::ONE_Q)) ?
            hhr_pkg::Q_W'(hhr_pkg::ONE_Q) : pix.level;

    lev2 = {lev_c, 1'b0};
    if (lev2 >= hhr_pkg::M2_W'(hhr_pkg::ONE_Q)) begin
      lev_dev = lev2 - hhr_pkg::M2_W'(hhr_pkg::ONE_Q);
    end else begin
      lev_dev = hhr_pkg::M2_W'(hhr_pkg::ONE_Q) - lev2;
    end

    s1_nxt.sector = sector;
    s1_nxt.f      = sector[0] ? (hhr_pkg::F_W'(hhr_pkg::SECTOR_W) - rem) : rem;
    s1_nxt.sat    = sat_c;
    s1_nxt.lev    = lev_c;
    s1_nxt.model  = model;
    if (model == hhr_pkg::MODEL_HSL) begin
      s1_nxt.mul_a = hhr_pkg::Q_W'(hhr_pkg::M2_W'(hhr_pkg::ONE_Q) - lev_dev);
    end else begin
      s1_nxt.mul_a = lev_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

/* sv/hhr_mult.sv */
module hhr_mult (
  input  logic         clk,
  input  logic         en_chroma,
  input  logic         en_prod,
  input  hhr_pkg::s1_t s1,
  output hhr_pkg::s3_t s3_r
);

  localparam int AxS_W = 2 * hhr_pkg::Q_W;
  localparam int CxF_W = hhr_pkg::Q_W + hhr_pkg::F_W;

  logic [AxS_W-1:0] axs;
  logic [CxF_W-1:0] cxf;
  hhr_pkg::s2_t     s2_r;
  hhr_pkg::s2_t     s2_nxt;
  hhr_pkg::s3_t     s3_nxt;

  always_comb begin
    axs            = AxS_W'(s1.mul_a) * AxS_W'(s1.sat);
    s2_nxt.sector  = s1.sector;
    s2_nxt.f       = s1.f;
    s2_nxt.c       = axs[hhr_pkg::FRAC_BITS +: hhr_pkg::Q_W];
    s2_nxt.lev     = s1.lev;
    s2_nxt.model   = s1.model;
  end

  always_comb begin
    cxf           = CxF_W'(s2_r.c) * CxF_W'(s2_r.f);
    s3_nxt.sector = s2_r.sector;
    s3_nxt.c      = s2_r.c;
    s3_nxt.prod   = hhr_pkg::PROD_W'(cxf);
    // doubled offset keeps HSL's half of c exact
    if (s2_r.model == hhr_pkg::MODEL_HSL) begin
      s3_nxt.m2 = {s2_r.lev, 1'b0} - {1'b0, s2_r.c};
    end else begin
      s3_nxt.m2 = {s2_r.lev, 1'b0} - {s2_r.c, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en_chroma) begin
      s2_r <= s2_nxt;
    end
    if (en_prod) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

/* sv/hhr_place.sv */
module hhr_place (
  input  logic         clk,
  input  logic         en_est,
  input  logic         en_place,
  input  hhr_pkg::s3_t s3,
  output hhr_pkg::s5_t s5_r
);

  localparam int EST_W = hhr_pkg::QUO_W + hhr_pkg::Q_W;
  localparam int REM_W = hhr_pkg::QUO_W + 1;

  logic [EST_W-1:0]        est_full;
  logic [REM_W-1:0]        est15;
  logic [REM_W-1:0]        rem;
  logic [hhr_pkg::Q_W-1:0] x;
  hhr_pkg::slot_map_t      map;
  hhr_pkg::s4_t            s4_r;
  hhr_pkg::s4_t            s4_nxt;
  hhr_pkg::s5_t            s5_nxt;

  function automatic logic [hhr_pkg::M2_W-1:0] chan2(
    input hhr_pkg::slot_t          slot,
    input logic [hhr_pkg::Q_W-1:0] c,
    input logic [hhr_pkg::Q_W-1:0] xv,
    input logic [hhr_pkg::M2_W-1:0] m2
  );
    logic [hhr_pkg::M2_W-1:0] v;
    unique case (slot)
      hhr_pkg::SLOT_C: v = {c, 1'b0} + m2;
      hhr_pkg::SLOT_X: v = {xv, 1'b0} + m2;
      default:         v = m2;
    endcase
    return v;
  endfunction

  // estimate of q / 15, low by at most one
  always_comb begin
    s4_nxt.sector = s3.sector;
    s4_nxt.c      = s3.c;
    s4_nxt.m2     = s3.m2;
    s4_nxt.q      = s3.prod[hhr_pkg::PROD_W-1:hhr_pkg::DIV_SHIFT];
    est_full      = EST_W'(s4_nxt.q) * EST_W'(hhr_pkg::RECIP);
    s4_nxt.est    = est_full[hhr_pkg::RECIP_SHIFT +: hhr_pkg::Q_W];
  end

  always_comb begin
    est15 = REM_W'(s4_r.est) * REM_W'(hhr_pkg::DIV_ODD);
    rem   = {1'b0, s4_r.q} - est15;
    x     = (rem >= REM_W'(hhr_pkg::DIV_ODD)) ? (s4_r.est + 1'b1) : s4_r.est;
    map   = hhr_pkg::sector_slots(s4_r.sector);
    s5_nxt.r2 = chan2(map.r, s4_r.c, x, s4_r.m2);
    s5_nxt.g2 = chan2(map.g, s4_r.c, x, s4_r.m2);
    s5_nxt.b2 = chan2(map.b, s4_r.c, x, s4_r.m2);
  end

  always_ff @(posedge clk) begin
    if (en_est) begin
      s4_r <= s4_nxt;
    end
    if (en_place) begin
      s5_r <= s5_nxt;
    end
  end

endmodule

/* sv/hhr_to_byte.sv */
module hhr_to_byte (
  input  logic                clk,
  input  logic                en,
  input  hhr_pkg::s5_t        s5,
  output hhr_pkg::pixel_out_t pix_r
);

  localparam int WIDE_W = hhr_pkg::M2_W + hhr_pkg::BYTE_W;
  localparam int TOP_W  = WIDE_W - (hhr_pkg::FRAC_BITS + 1);

  hhr_pkg::pixel_out_t pix_nxt;

  // floor(v2 * 255 / 2^(F+1)), clipped to 255
  function automatic logic [hhr_pkg::BYTE_W-1:0] scale(
    input logic [hhr_pkg::M2_W-1:0] v2
  );
    logic [WIDE_W-1:0] wide;
    logic [TOP_W-1:0]  top;
    wide = {v2, {hhr_pkg::BYTE_W{1'b0}}} - WIDE_W'(v2);
    top  = wide[WIDE_W-1:hhr_pkg::FRAC_BITS+1];
    return (top > TOP_W'(255)) ? 8'hFF : top[hhr_pkg::BYTE_W-1:0];
  endfunction

  always_comb begin
    pix_nxt.red   = scale(s5.r2);
    pix_nxt.green = scale(s5.g2);
    pix_nxt.blue  = scale(s5.b2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

/* sv/hsv_hsl_to_rgb_converter.sv */
// HSV / HSL to 8-bit RGB converter.
// Input channel: in_valid / in_stall with in_pixel (hue in 1/64 degree,
//   saturation and level as Q12). An item is taken when in_valid is high
//   and in_stall is low.
// Output channel: out_valid / out_stall with out_pixel (red, green, blue).
// Config: cfg_valid / cfg_ready write cfg_data into the model select
//   (0 HSV, 1 HSL); cfg_ready is always high. Write only while idle.
// Six register stages: clamp and sector, chroma multiply, c*f multiply,
//   reciprocal divide estimate, divide correction and sector placement,
//   byte scaling. out_valid is the valid bit of the byte-scaling stage.
// Throughput is one item per clock while out_stall is low; each stage holds
//   when the stage after it is full and stalled, and empty stages fill, so
//   in_stall rises only when all six stages hold items and out_stall is high.
// Reset clears all stage valid bits and selects HSV; no item is lost or
//   repeated across a stall.
module hsv_hsl_to_rgb_converter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hhr_pkg::pixel_in_t  in_pixel,
  output logic                out_valid,
  input  logic                out_stall,
  output hhr_pkg::pixel_out_t out_pixel,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;
  hhr_pkg::model_t model_r;
  hhr_pkg::model_t model_nxt;
  hhr_pkg::s1_t    s1;
  hhr_pkg::s3_t    s3;
  hhr_pkg::s5_t    s5;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NSTG-1];
  assign cfg_ready = 1'b1;

  always_comb begin
    model_nxt = model_r;
    if (cfg_valid && cfg_ready) begin
      model_nxt = hhr_pkg::model_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      model_r <= hhr_pkg::MODEL_HSV;
    end else begin
      vld_r   <= vld_nxt;
      model_r <= model_nxt;
    end
  end

  hhr_prep u_prep (
    .clk   (clk),
    .en    (adv[0]),
    .pix   (in_pixel),
    .model (model_r),
    .s1_r  (s1)
  );

  hhr_mult u_mult (
    .clk       (clk),
    .en_chroma (adv[1]),
    .en_prod   (adv[2]),
    .s1        (s1),
    .s3_r      (s3)
  );

  hhr_place u_place (
    .clk      (clk),
    .en_est   (adv[3]),
    .en_place (adv[4]),
    .s3       (s3),
    .s5_r     (s5)
  );

  hhr_to_byte u_to_byte (
    .clk   (clk),
    .en    (adv[5]),
    .s5    (s5),
    .pix_r (out_pixel)
  );

endmodule

/* sv/hhr_checker.sv */
`include "hsv_hsl_to_rgb_converter_macros.svh"

module hhr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input hhr_pkg::pixel_out_t out_pixel
);

  // a stalled result stays and holds its value
  `HHR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out item dropped")
  `HHR_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_pixel), "out item changed")

  // input backs up only when the output holds an item and is stalled
  `HHR_ASSERT_NOW(a_stall_full, in_stall, out_valid && out_stall, "input stalled with room")

  `HHR_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "out_valid after reset")

endmodule

bind hsv_hsl_to_rgb_converter hhr_checker u_hhr_checker (.*);
